/* rtl/core/tct_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tct_pkg: shared types and constants of the connection timer table
// Field widths, operation and event codes, register indexes and the layout
// of one connection entry as it is held in the state memory.
// ----------------------------------------------------------------------------
package tct_pkg;

  // Field widths
  localparam int OP_W       = 3;
  localparam int CONN_W     = 4;
  localparam int RES_W      = 3;
  localparam int LVL_W      = 3;
  localparam int SCAN_W     = 20;
  localparam int TW_W       = 28;
  localparam int RI_W       = 24;
  localparam int RLEFT_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 28;

  // Default parameter values
  localparam int DEF_CONNECTIONS = 16;
  localparam int DEF_RETRY_LIMIT = 4;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_RETX  = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP_RETX = 3'd2;
  localparam logic [OP_W-1:0] OP_ARM_WAIT  = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_PEND  = 3'd4;

  // Event codes
  localparam logic [RES_W-1:0] EV_DONE        = 3'd0;
  localparam logic [RES_W-1:0] EV_RETRANSMIT  = 3'd1;
  localparam logic [RES_W-1:0] EV_CLOSE_WAIT  = 3'd2;
  localparam logic [RES_W-1:0] EV_CLOSE_IDLE  = 3'd3;
  localparam logic [RES_W-1:0] EV_CLOSE_LIMIT = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_INTERVAL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEWAIT_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RETRANS_INITIAL  = 2'd2;

  // Register reset values
  localparam logic [SCAN_W-1:0] RST_SCAN_INTERVAL    = 20'd10000;
  localparam logic [TW_W-1:0]   RST_TIMEWAIT_TIMEOUT = 28'd2000000;
  localparam logic [RI_W-1:0]   RST_RETRANS_INITIAL  = 24'd200000;

  // Configuration seen by the entry update logic
  typedef struct packed {
    logic [SCAN_W-1:0] scan_interval;
    logic [TW_W-1:0]   timewait_timeout;
    logic [RI_W-1:0]   retrans_initial;
  } cfg_t;

  // One connection entry; all zero is the reset state
  typedef struct packed {
    logic               retrans_active;
    logic [LVL_W-1:0]   retrans_level;
    logic [RLEFT_W-1:0] retrans_left;
    logic               wait_active;
    logic [TW_W-1:0]    wait_left;
    logic               send_pending;
  } entry_t;

  // Updated entry and up to two events for one connection
  typedef struct packed {
    entry_t           entry;
    logic             a_vld;
    logic [RES_W-1:0] a_code;
    logic             b_vld;
    logic [RES_W-1:0] b_code;
  } eval_t;

endpackage : tct_pkg
`default_nettype wire

/* rtl/core/tct_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tct_mem: connection state memory
// One write port and one registered read port. A valid bit per entry is
// cleared at reset, so an entry not yet written reads as all zero.
// ----------------------------------------------------------------------------
module tct_mem import tct_pkg::*; #(
  parameter int CONNECTIONS = DEF_CONNECTIONS,
  parameter int ADDR_W      = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire entry_t            wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output entry_t                 rd_data_o
);

  entry_t                 mem_q [CONNECTIONS];
  logic [CONNECTIONS-1:0] valid_q;
  entry_t                 rd_data_q;
  logic                   rd_valid_q;

  // Storage array and read data register
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Entry valid bits and the valid flag of the read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule : tct_mem
`default_nettype wire

/* rtl/core/tct_eval.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tct_eval: entry update for one connection
// Applies a tick or a timer operation to one entry read from memory and
// reports the events that the tick raises.
// ----------------------------------------------------------------------------
module tct_eval import tct_pkg::*; #(
  parameter int RETRY_LIMIT = DEF_RETRY_LIMIT
) (
  input  wire entry_t          entry_i,
  input  wire logic            tick_i,
  input  wire logic [OP_W-1:0] op_i,
  input  wire logic            keep_i,
  input  wire logic            pend_i,
  input  wire cfg_t            cfg_i,
  output eval_t                res_o
);

  localparam logic [LVL_W-1:0] LIMIT = LVL_W'(RETRY_LIMIT);

  logic               r_exp;
  logic               w_exp;
  logic               closed;
  logic [RLEFT_W-1:0] scan_r;
  logic [TW_W-1:0]    scan_w;

  assign scan_r = RLEFT_W'(cfg_i.scan_interval);
  assign scan_w = TW_W'(cfg_i.scan_interval);
  assign r_exp  = entry_i.retrans_left <= scan_r;
  assign w_exp  = entry_i.wait_left <= scan_w;

  always_comb begin
    res_o        = '0;
    res_o.entry  = entry_i;
    closed       = 1'b0;
    if (tick_i) begin
      // Retransmit timer first
      if (entry_i.retrans_active) begin
        if (r_exp) begin
          res_o.a_vld = 1'b1;
          if (entry_i.retrans_level < LIMIT) begin
            if (!entry_i.send_pending) begin
              res_o.a_code = EV_CLOSE_IDLE;
              closed       = 1'b1;
            end else begin
              // Backoff: the reload doubles with every retry
              res_o.a_code             = EV_RETRANSMIT;
              res_o.entry.retrans_level = entry_i.retrans_level + 1'b1;
              res_o.entry.retrans_left  =
                RLEFT_W'(cfg_i.retrans_initial) << entry_i.retrans_level;
            end
          end else begin
            res_o.a_code = EV_CLOSE_LIMIT;
            closed       = 1'b1;
          end
        end else begin
          res_o.entry.retrans_left = entry_i.retrans_left - scan_r;
        end
      end
      // Time-wait timer, skipped when the connection already closed
      if (!closed && entry_i.wait_active) begin
        if (w_exp) begin
          if (!entry_i.send_pending) begin
            res_o.b_vld  = 1'b1;
            res_o.b_code = EV_CLOSE_WAIT;
            closed       = 1'b1;
          end else begin
            res_o.entry.wait_left = cfg_i.timewait_timeout;
          end
        end else begin
          res_o.entry.wait_left = entry_i.wait_left - scan_w;
        end
      end
      if (closed) begin
        res_o.entry.retrans_active = 1'b0;
        res_o.entry.wait_active    = 1'b0;
      end
    end else begin
      unique case (op_i)
        OP_SET_RETX: begin
          if (!entry_i.retrans_active || !keep_i) begin
            res_o.entry.retrans_active = 1'b1;
            res_o.entry.retrans_level  = LVL_W'(1);
            res_o.entry.retrans_left   = RLEFT_W'(cfg_i.retrans_initial);
          end
        end
        OP_STOP_RETX: res_o.entry.retrans_active = 1'b0;
        OP_ARM_WAIT: begin
          res_o.entry.wait_active = 1'b1;
          res_o.entry.wait_left   = cfg_i.timewait_timeout;
        end
        OP_SET_PEND: res_o.entry.send_pending = pend_i;
        default: ;
      endcase
    end
  end

endmodule : tct_eval
`default_nettype wire

/* rtl/core/tcp_connection_timer_table_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_connection_timer_table_top: per-connection timer table
// Retransmit timers with exponential backoff and time-wait timers for a set
// of connections, kept in a state memory and updated by read-modify-write.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  s_axis    in         op, conn, keep_running, pending_value
//  m_axis    out        event_res, event_conn; tlast on the final result
//  cfg       in         register index and write data
//
//  A timer op is accepted with a memory read, then updated and written back
//  together with its done result. A tick walks every connection; the
//  memory read port sets one connection per cycle when no stall or second
//  event comes between. Reset clears the memory through per-entry valid
//  bits, so no clearing pass is needed. A stalled output holds the walk
//  until the pending result is taken.
// ----------------------------------------------------------------------------
module tcp_connection_timer_table_top import tct_pkg::*; #(
  parameter int CONNECTIONS = DEF_CONNECTIONS,
  parameter int RETRY_LIMIT = DEF_RETRY_LIMIT
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Input stream: [2:0] op, [6:3] conn, [7] keep_running, [8] pending_value
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [15:0]           s_axis_tdata,
  // Output stream: [2:0] event_res, [6:3] event_conn
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [7:0]                 m_axis_tdata,
  output logic                       m_axis_tlast,
  // Configuration write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int ADDR_W = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CONNECTIONS - 1);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_EV2  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [CONN_W-1:0] conn_q, conn_d;
  logic              keep_q, keep_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [RES_W-1:0]  ev2_q, ev2_d;
  cfg_t              cfg_q;

  logic              out_valid_q;
  logic [RES_W-1:0]  out_res_q;
  logic [CONN_W-1:0] out_conn_q;
  logic              out_last_q;
  logic              out_load;
  logic [RES_W-1:0]  out_res_d;
  logic [CONN_W-1:0] out_conn_d;
  logic              out_last_d;
  logic              out_free;

  logic              in_accept;
  logic [OP_W-1:0]   in_op;
  logic [CONN_W-1:0] in_conn;
  logic              is_tick;
  logic              advance;
  logic              rd_en;
  logic              wr_en;
  entry_t            rd_data;
  eval_t             ev;
  logic [CONN_W-1:0] addr_conn;

  assign in_op     = s_axis_tdata[2:0];
  assign in_conn   = s_axis_tdata[6:3];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign is_tick   = op_q == OP_TICK;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign addr_conn = CONN_W'(addr_q);

  // Configuration registers; the channel never stalls
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scan_interval    <= RST_SCAN_INTERVAL;
      cfg_q.timewait_timeout <= RST_TIMEWAIT_TIMEOUT;
      cfg_q.retrans_initial  <= RST_RETRANS_INITIAL;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SCAN_INTERVAL:    cfg_q.scan_interval    <= cfg_data_i[SCAN_W-1:0];
        REG_TIMEWAIT_TIMEOUT: cfg_q.timewait_timeout <= cfg_data_i[TW_W-1:0];
        REG_RETRANS_INITIAL:  cfg_q.retrans_initial  <= cfg_data_i[RI_W-1:0];
        default: ;
      endcase
    end
  end

  // State memory and entry update
  tct_mem #(
    .CONNECTIONS(CONNECTIONS),
    .ADDR_W     (ADDR_W)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_addr_i(addr_q),
    .wr_data_i(ev.entry),
    .rd_en_i  (rd_en),
    .rd_addr_i(addr_d),
    .rd_data_o(rd_data)
  );

  tct_eval #(
    .RETRY_LIMIT(RETRY_LIMIT)
  ) u_eval (
    .entry_i(rd_data),
    .tick_i (is_tick),
    .op_i   (op_q),
    .keep_i (keep_q),
    .pend_i (pend_q),
    .cfg_i  (cfg_q),
    .res_o  (ev)
  );

  // Sequencer: accept, read-modify-write per entry, emit results
  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    conn_d        = conn_q;
    keep_d        = keep_q;
    pend_d        = pend_q;
    addr_d        = addr_q;
    ev2_d         = ev2_q;
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    advance       = 1'b0;
    out_load      = 1'b0;
    out_res_d     = EV_DONE;
    out_conn_d    = conn_q;
    out_last_d    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          op_d   = in_op;
          conn_d = in_conn;
          keep_d = s_axis_tdata[7];
          pend_d = s_axis_tdata[8];
          if (in_op == OP_TICK) begin
            addr_d  = '0;
            rd_en   = 1'b1;
            state_d = ST_EVAL;
          end else if ((in_op == OP_SET_RETX || in_op == OP_STOP_RETX ||
                        in_op == OP_ARM_WAIT || in_op == OP_SET_PEND) &&
                       (32'(in_conn) < CONNECTIONS)) begin
            addr_d  = ADDR_W'(in_conn);
            rd_en   = 1'b1;
            state_d = ST_EVAL;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_EVAL: begin
        if (is_tick) begin
          if (!(ev.a_vld || ev.b_vld) || out_free) begin
            wr_en      = 1'b1;
            out_conn_d = addr_conn;
            if (ev.a_vld && ev.b_vld) begin
              out_load  = 1'b1;
              out_res_d = ev.a_code;
              ev2_d     = ev.b_code;
              state_d   = ST_EV2;
            end else if (ev.a_vld) begin
              out_load  = 1'b1;
              out_res_d = ev.a_code;
              advance   = 1'b1;
            end else if (ev.b_vld) begin
              out_load  = 1'b1;
              out_res_d = ev.b_code;
              advance   = 1'b1;
            end else begin
              advance = 1'b1;
            end
          end
        end else if (out_free) begin
          // Timer op: write back and report done at once
          wr_en      = 1'b1;
          out_load   = 1'b1;
          out_last_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_EV2: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_res_d  = ev2_q;
          out_conn_d = addr_conn;
          advance    = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last_d = 1'b1;
          out_conn_d = is_tick ? '0 : conn_q;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // Move the tick walk to the next connection or finish it
    if (advance) begin
      if (addr_q == LAST_ADDR) begin
        state_d = ST_DONE;
      end else begin
        addr_d  = addr_q + 1'b1;
        rd_en   = 1'b1;
        state_d = ST_EVAL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    conn_q <= conn_d;
    keep_q <= keep_d;
    pend_q <= pend_d;
    addr_q <= addr_d;
    ev2_q  <= ev2_d;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q  <= out_res_d;
      out_conn_q <= out_conn_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_conn_q, out_res_q};
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
  // A result is only loaded into a free output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result loaded over a pending transfer");

  // Write-back never coincides with a new input transfer
  a_wr_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && in_accept))
    else $error("memory write during input transfer");

  // An accepted item always leaves the idle state
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q != ST_IDLE)
    else $error("sequencer stayed idle after input transfer");

  // The final result of an item returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last_d) |=> state_q == ST_IDLE)
    else $error("final result without return to idle");
`endif

endmodule : tcp_connection_timer_table_top
`default_nettype wire
